@@ rtl/bbo_pkg.sv @@
// Shared types, constants and codes for the box outline overlay block.
`default_nettype none
package bbo_pkg;

  // Box table size and derived widths.
  localparam int MAX_BOXES = 16;
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);
  localparam int COORD_W   = 12;
  localparam int COLOR_W   = 16;
  localparam int PROD_W    = 2 * COORD_W;

  // Action codes of an input transfer.
  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_PIXEL = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_FRAME_W  = 2'd0;
  localparam logic [1:0] REG_FRAME_H  = 2'd1;
  localparam logic [1:0] REG_SOURCE_W = 2'd2;
  localparam logic [1:0] REG_SOURCE_H = 2'd3;

  // Box add sequencer states.
  typedef enum logic [2:0] {
    ADD_IDLE,
    ADD_MUL,
    ADD_DIV,
    ADD_WAIT,
    ADD_CHECK
  } add_state_t;

  // One pixel as it travels down the cell row.
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COLOR_W-1:0] pix;
    logic               hit;
    logic               last;
  } pix_t;

  // One stored box in frame coordinates.
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
    logic [COLOR_W-1:0] color;
  } box_t;

endpackage
`default_nettype wire

@@ rtl/bbo_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module bbo_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [bbo_pkg::PROD_W-1:0]  dividend,
  input  wire logic [bbo_pkg::COORD_W-1:0] divisor,
  output logic                            done,
  output logic [bbo_pkg::PROD_W-1:0]       quotient
);
  import bbo_pkg::*;

  localparam int STEP_W = $clog2(PROD_W);

  logic                run;
  logic [STEP_W-1:0]   step;
  logic [COORD_W-1:0]  rem;
  logic [COORD_W-1:0]  dvs;
  logic [COORD_W:0]    trial;
  logic                ge;
  logic [COORD_W:0]    diff;

  // Shift in the next dividend bit and try a subtraction.
  assign trial = {rem, quotient[PROD_W-1]};
  assign ge    = (trial >= {1'b0, dvs});
  assign diff  = trial - {1'b0, dvs};

  // Control: step through the quotient bits, then raise done.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 1'b1;
        if (step == STEP_W'(PROD_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient shares the dividend register.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (run) begin
      rem      <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
      quotient <= {quotient[PROD_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

@@ rtl/bbo_cell.sv @@
// One cell of the box row: holds one box and recolors passing pixels on its outline.
`default_nettype none
module bbo_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clr,
  input  wire logic          we,
  input  wire bbo_pkg::box_t box_in,
  input  wire logic          adv,
  input  wire logic          valid_in,
  input  wire bbo_pkg::pix_t pix_in,
  output logic               valid_out,
  output bbo_pkg::pix_t      pix_out
);
  import bbo_pkg::*;

  logic  box_valid;
  box_t  box;
  logic  in_box;
  logic  on_edge;
  pix_t  pix_next;

  // Box storage; the valid bit marks a written entry.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      box_valid <= 1'b0;
    end else if (we) begin
      box_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      box <= box_in;
    end
  end

  // Outline test; a later cell holds a later box and so wins.
  assign in_box  = (pix_in.col >= box.left) && (pix_in.col <= box.right) &&
                   (pix_in.row >= box.top) && (pix_in.row <= box.bottom);
  assign on_edge = (pix_in.col == box.left) || (pix_in.col == box.right) ||
                   (pix_in.row == box.top) || (pix_in.row == box.bottom);

  always_comb begin
    pix_next = pix_in;
    if (box_valid && in_box && on_edge) begin
      pix_next.pix = box.color;
      pix_next.hit = 1'b1;
    end
  end

  // Hand the pixel to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_out <= pix_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/box_outline_overlay_core.sv @@
// Top level: raster counter, box add sequencer and the row of box cells.
// Each pixel passes through the register of every cell in the row before it leaves.
// Throughput: one pixel per cycle while out_ready stays high and no box add is in progress.
// A box add goes straight to ADD_CHECK, or when scaling first makes four multiply and divide rounds.
// Adds and clears wait until the cell row has drained.
// Synchronous reset clears the box row, count, raster position and registers to defaults.
`default_nettype none
module box_outline_overlay_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  action,
  input  wire logic [bbo_pkg::COORD_W-1:0] box_left,
  input  wire logic [bbo_pkg::COORD_W-1:0] box_top,
  input  wire logic [bbo_pkg::COORD_W-1:0] box_width,
  input  wire logic [bbo_pkg::COORD_W-1:0] box_height,
  input  wire logic [bbo_pkg::COLOR_W-1:0] box_color,
  input  wire logic [bbo_pkg::COLOR_W-1:0] pixel_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [bbo_pkg::COLOR_W-1:0]      pixel_out,
  output logic                             pixel_hit,
  output logic                             frame_end,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [bbo_pkg::COORD_W-1:0] cfg_data
);
  import bbo_pkg::*;

  logic [COORD_W-1:0] frame_width;
  logic [COORD_W-1:0] frame_height;
  logic [COORD_W-1:0] source_width;
  logic [COORD_W-1:0] source_height;
  logic [COORD_W-1:0] fw;
  logic [COORD_W-1:0] fh;
  logic [COORD_W-1:0] sw;
  logic [COORD_W-1:0] sh;
  logic               scale;

  logic               accept;
  logic               acc_clear;
  logic               acc_add;
  logic               acc_pixel;
  logic               adv;
  logic               pipe_empty;

  logic [COORD_W-1:0] raster_col;
  logic [COORD_W-1:0] raster_row;
  logic               row_end;
  logic               frame_last;
  logic [COORD_W:0]   col_inc;
  logic [COORD_W:0]   row_inc;

  logic [CNT_W-1:0]   box_count;
  add_state_t         state;
  add_state_t         state_next;
  logic [1:0]         op_idx;
  logic [PROD_W-1:0]  op [4];
  logic [COLOR_W-1:0] color;
  logic [PROD_W-1:0]  prod;
  logic [COORD_W-1:0] op_sel;
  logic [COORD_W-1:0] dim_sel;
  logic [COORD_W-1:0] dvs_sel;
  logic               div_start;
  logic               div_done;
  logic [PROD_W-1:0]  quotient;
  logic               add_skip;

  logic [PROD_W-1:0]  bw_eff;
  logic [PROD_W-1:0]  bh_eff;
  logic [PROD_W:0]    x2;
  logic [PROD_W:0]    y2;
  logic               box_ok;
  logic               add_we;
  box_t               new_box;

  logic               cell_v   [MAX_BOXES];
  pix_t               cell_pix [MAX_BOXES];
  logic               first_v;
  pix_t               first_pix;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= COORD_W'(240);
      frame_height  <= COORD_W'(240);
      source_width  <= '0;
      source_height <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_W:  frame_width   <= cfg_data;
        REG_FRAME_H:  frame_height  <= cfg_data;
        REG_SOURCE_W: source_width  <= cfg_data;
        REG_SOURCE_H: source_height <= cfg_data;
        default:      frame_width   <= frame_width;
      endcase
    end
  end

  // Effective sizes: a zero frame size acts as one, a zero source size as the frame.
  assign fw    = (frame_width == '0) ? COORD_W'(1) : frame_width;
  assign fh    = (frame_height == '0) ? COORD_W'(1) : frame_height;
  assign sw    = (source_width == '0) ? fw : source_width;
  assign sh    = (source_height == '0) ? fh : source_height;
  assign scale = (sw != fw) || (sh != fh);

  // Input handshake: pixels flow with the row, other actions wait for an idle block.
  assign adv        = !out_valid || out_ready;
  always_comb begin
    pipe_empty = 1'b1;
    for (int i = 0; i < MAX_BOXES; i++) begin
      if (cell_v[i]) begin
        pipe_empty = 1'b0;
      end
    end
  end

  always_comb begin
    if (state != ADD_IDLE) begin
      in_ready = 1'b0;
    end else if (action == ACT_PIXEL) begin
      in_ready = adv;
    end else begin
      in_ready = pipe_empty;
    end
  end

  assign accept    = in_valid && in_ready;
  assign acc_clear = accept && (action == ACT_CLEAR);
  assign acc_add   = accept && (action == ACT_ADD);
  assign acc_pixel = accept && (action == ACT_PIXEL);

  // Raster position of the next pixel.
  assign col_inc    = {1'b0, raster_col} + 1'b1;
  assign row_inc    = {1'b0, raster_row} + 1'b1;
  assign row_end    = (col_inc >= {1'b0, fw});
  assign frame_last = row_end && (row_inc >= {1'b0, fh});

  always_ff @(posedge clk) begin
    if (rst || acc_clear) begin
      raster_col <= '0;
      raster_row <= '0;
    end else if (acc_pixel) begin
      if (row_end) begin
        raster_col <= '0;
        raster_row <= frame_last ? '0 : row_inc[COORD_W-1:0];
      end else begin
        raster_col <= col_inc[COORD_W-1:0];
      end
    end
  end

  // Box add sequencer: next state.
  assign add_skip = (box_count >= CNT_W'(MAX_BOXES)) ||
                    (box_width == '0) || (box_height == '0);

  always_comb begin
    state_next = state;
    unique case (state)
      ADD_IDLE: begin
        if (acc_add && !add_skip) begin
          state_next = scale ? ADD_MUL : ADD_CHECK;
        end
      end
      ADD_MUL:   state_next = ADD_DIV;
      ADD_DIV:   state_next = ADD_WAIT;
      ADD_WAIT: begin
        if (div_done) begin
          state_next = (op_idx == 2'd3) ? ADD_CHECK : ADD_MUL;
        end
      end
      ADD_CHECK: state_next = ADD_IDLE;
      default:   state_next = ADD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ADD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Box add sequencer: outputs.
  always_comb begin
    div_start = 1'b0;
    add_we    = 1'b0;
    unique case (state)
      ADD_DIV:   div_start = 1'b1;
      ADD_CHECK: add_we    = box_ok;
      default: begin
        div_start = 1'b0;
        add_we    = 1'b0;
      end
    endcase
  end

  // Operand selection: even operands scale by width, odd ones by height.
  assign op_sel  = op[op_idx][COORD_W-1:0];
  assign dim_sel = op_idx[0] ? fh : fw;
  assign dvs_sel = op_idx[0] ? sh : sw;

  // Box operands: loaded on the transfer, replaced by their scaled values.
  always_ff @(posedge clk) begin
    if (acc_add) begin
      op[0]  <= PROD_W'(box_left);
      op[1]  <= PROD_W'(box_top);
      op[2]  <= PROD_W'(box_width);
      op[3]  <= PROD_W'(box_height);
      color  <= box_color;
      op_idx <= 2'd0;
    end else begin
      if (state == ADD_MUL) begin
        prod <= op_sel * dim_sel;
      end
      if (state == ADD_WAIT && div_done) begin
        op[op_idx] <= quotient;
        op_idx     <= op_idx + 2'd1;
      end
    end
  end

  bbo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (dvs_sel),
    .done     (div_done),
    .quotient (quotient)
  );

  // Final check: size floor of one, drop boxes starting off frame, clip the far corner.
  assign bw_eff = (op[2] == '0) ? PROD_W'(1) : op[2];
  assign bh_eff = (op[3] == '0) ? PROD_W'(1) : op[3];
  assign x2     = {1'b0, op[0]} + {1'b0, bw_eff} - 1'b1;
  assign y2     = {1'b0, op[1]} + {1'b0, bh_eff} - 1'b1;
  assign box_ok = (op[0] < PROD_W'(fw)) && (op[1] < PROD_W'(fh));

  always_comb begin
    new_box.left   = op[0][COORD_W-1:0];
    new_box.top    = op[1][COORD_W-1:0];
    new_box.right  = (x2 >= (PROD_W + 1)'(fw)) ? (fw - 1'b1) : x2[COORD_W-1:0];
    new_box.bottom = (y2 >= (PROD_W + 1)'(fh)) ? (fh - 1'b1) : y2[COORD_W-1:0];
    new_box.color  = color;
  end

  // Box count: selects the cell that takes the next box.
  always_ff @(posedge clk) begin
    if (rst || acc_clear) begin
      box_count <= '0;
    end else if (add_we) begin
      box_count <= box_count + 1'b1;
    end
  end

  // Pixel entering the first cell.
  assign first_v = acc_pixel;
  always_comb begin
    first_pix.col  = raster_col;
    first_pix.row  = raster_row;
    first_pix.pix  = pixel_in;
    first_pix.hit  = 1'b0;
    first_pix.last = frame_last;
  end

  // Row of cells; box i lives in cell i.
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    if (i == 0) begin : g_head
      bbo_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .clr       (acc_clear),
        .we        (add_we && (box_count == CNT_W'(i))),
        .box_in    (new_box),
        .adv       (adv),
        .valid_in  (first_v),
        .pix_in    (first_pix),
        .valid_out (cell_v[i]),
        .pix_out   (cell_pix[i])
      );
    end else begin : g_body
      bbo_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .clr       (acc_clear),
        .we        (add_we && (box_count == CNT_W'(i))),
        .box_in    (new_box),
        .adv       (adv),
        .valid_in  (cell_v[i-1]),
        .pix_in    (cell_pix[i-1]),
        .valid_out (cell_v[i]),
        .pix_out   (cell_pix[i])
      );
    end
  end

  // The last cell is the output register.
  assign out_valid = cell_v[MAX_BOXES-1];
  assign pixel_out = cell_pix[MAX_BOXES-1].pix;
  assign pixel_hit = cell_pix[MAX_BOXES-1].hit;
  assign frame_end = cell_pix[MAX_BOXES-1].last;

endmodule
`default_nettype wire
